>>> hdl/mp2d_pkg.sv
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared constants and types of the streaming 2-D max pooling block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mp2d_pkg;

    // default sizing of the block
    localparam int DEF_MAX_LINE_WIDTH = 1024;
    localparam int DEF_MAX_POOL       = 8;
    localparam int DEF_SAMPLE_BITS    = 16;

    // register values after reset
    localparam int RST_LINE_WIDTH   = 64;
    localparam int RST_PLANE_HEIGHT = 64;
    localparam int RST_POOL_WIDTH   = 2;
    localparam int RST_POOL_HEIGHT  = 2;

    // configuration register index
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LINE_WIDTH   = 2'd0,
        CFG_PLANE_HEIGHT = 2'd1,
        CFG_POOL_WIDTH   = 2'd2,
        CFG_POOL_HEIGHT  = 2'd3
    } t_cfg_idx;

endpackage

>>> hdl/mp2d_in_if.sv
// ----------------------------------------------------------------------------
// mp2d_in_if
// Sample channel: one feature sample per word, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mp2d_in_if #(
    parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

>>> hdl/mp2d_out_if.sv
// ----------------------------------------------------------------------------
// mp2d_out_if
// Result channel: one pooled value and its end-of-plane flag per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mp2d_out_if #(
    parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] pooled_value;
    logic                          plane_done;

    modport source (output valid, output pooled_value, output plane_done, input ready);
    modport sink   (input valid, input pooled_value, input plane_done, output ready);
endinterface

>>> hdl/mp2d_ram.sv
// ----------------------------------------------------------------------------
// mp2d_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mp2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/max_pooling_2d_stream.sv
// ----------------------------------------------------------------------------
// max_pooling_2d_stream
// Streaming non-overlapping 2-D max pooling. Samples of feature planes come
// in raster order (x fastest, then rows, then planes); each pool_width by
// pool_height window yields its maximum when its last sample arrives, in
// raster order of the pooled plane, with plane_done set on the last result
// of a plane. Samples of incomplete right or bottom edge windows are consumed
// and produce nothing. The block takes one sample word per clock cycle while
// the output side takes results; a result word passes from stage 1 into the
// output register. The rate rests on the line store of partial column maxima:
// a single RAM read at acceptance and a write from stage 1, with a bypass for
// a one-sample line. It needs no clearing pass: every merged read follows a
// write of its column in the previous row of the same window. A write to any
// configuration register restarts the stream position at the first sample
// of a plane; write registers only while the block is idle. Out-of-range
// register values saturate to the legal range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_pooling_2d_stream #(
    parameter int MAX_LINE_WIDTH = mp2d_pkg::DEF_MAX_LINE_WIDTH,
    parameter int MAX_POOL       = mp2d_pkg::DEF_MAX_POOL,
    parameter int SAMPLE_BITS    = mp2d_pkg::DEF_SAMPLE_BITS,
    localparam int LW_BITS  = $clog2(MAX_LINE_WIDTH + 1),
    localparam int PL_BITS  = $clog2(MAX_POOL + 1),
    localparam int CFG_BITS = (LW_BITS > PL_BITS) ? LW_BITS : PL_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  mp2d_pkg::t_cfg_idx      i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    mp2d_in_if.sink                 i_in,
    mp2d_out_if.source              o_out
);
    import mp2d_pkg::*;

    localparam int AW       = $clog2(MAX_LINE_WIDTH);   // line store address
    localparam int OW       = $clog2(MAX_POOL);         // offset inside window
    localparam int SUM_BITS = LW_BITS + 1;

    localparam logic [LW_BITS-1:0] LW_MAX  = LW_BITS'(MAX_LINE_WIDTH);
    localparam logic [PL_BITS-1:0] PL_MAX  = PL_BITS'(MAX_POOL);
    localparam logic [LW_BITS-1:0] LW_RST  =
        LW_BITS'((RST_LINE_WIDTH > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : RST_LINE_WIDTH);
    localparam logic [LW_BITS-1:0] PH_RST  =
        LW_BITS'((RST_PLANE_HEIGHT > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : RST_PLANE_HEIGHT);
    localparam logic [PL_BITS-1:0] PW_RST  =
        PL_BITS'((RST_POOL_WIDTH > MAX_POOL) ? MAX_POOL : RST_POOL_WIDTH);
    localparam logic [PL_BITS-1:0] PHT_RST =
        PL_BITS'((RST_POOL_HEIGHT > MAX_POOL) ? MAX_POOL : RST_POOL_HEIGHT);

    // ------------------------------------------------------------------
    // Configuration registers, saturated on write
    // ------------------------------------------------------------------
    logic [LW_BITS-1:0] r_line_width, r_plane_height;
    logic [PL_BITS-1:0] r_pool_width, r_pool_height;
    logic [LW_BITS-1:0] cfg_lw_sat;
    logic [PL_BITS-1:0] cfg_pl_sat;

    always_comb begin
        // clamp the write data once for each register class
        if (i_cfg_data == '0) begin
            cfg_lw_sat = LW_BITS'(1);
            cfg_pl_sat = PL_BITS'(1);
        end else begin
            cfg_lw_sat = (SUM_BITS'(i_cfg_data) > SUM_BITS'(LW_MAX)) ? LW_MAX
                       : LW_BITS'(i_cfg_data);
            cfg_pl_sat = (CFG_BITS'(i_cfg_data) > CFG_BITS'(PL_MAX)) ? PL_MAX
                       : PL_BITS'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LW_RST;
            r_plane_height <= PH_RST;
            r_pool_width   <= PW_RST;
            r_pool_height  <= PHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LINE_WIDTH:   r_line_width   <= cfg_lw_sat;
                CFG_PLANE_HEIGHT: r_plane_height <= cfg_lw_sat;
                CFG_POOL_WIDTH:   r_pool_width   <= cfg_pl_sat;
                CFG_POOL_HEIGHT:  r_pool_height  <= cfg_pl_sat;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic r_s1_v, r_s1_wr, r_s1_emit, r_s1_merge, r_s1_done;
    logic r_o_v;
    logic s1_adv, in_acc;

    // stage 1 only waits on the output register when it has a result to hand over
    assign s1_adv     = r_s1_v && (!r_s1_emit || !r_o_v || o_out.ready);
    assign i_in.ready = !r_s1_v || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    // ------------------------------------------------------------------
    // Stage 0: stream position and running row maximum, updated on accept
    // ------------------------------------------------------------------
    logic [AW-1:0] r_col, r_row;
    logic [OW-1:0] r_ox, r_oy;
    logic signed [SAMPLE_BITS-1:0] r_row_max;

    logic [AW-1:0] n_col, n_row;
    logic [OW-1:0] n_ox, n_oy;
    logic signed [SAMPLE_BITS-1:0] n_row_max;
    logic line_ok, rows_ok, win_x_last, win_y_last, plane_last;

    always_comb begin
        // does the current window fit inside the row and the plane
        line_ok = (SUM_BITS'(r_col) - SUM_BITS'(r_ox) + SUM_BITS'(r_pool_width))
                  <= SUM_BITS'(r_line_width);
        rows_ok = (SUM_BITS'(r_row) - SUM_BITS'(r_oy) + SUM_BITS'(r_pool_height))
                  <= SUM_BITS'(r_plane_height);
        win_x_last = (PL_BITS'(r_ox) + PL_BITS'(1)) == r_pool_width;
        win_y_last = (PL_BITS'(r_oy) + PL_BITS'(1)) == r_pool_height;
        plane_last = ((SUM_BITS'(r_col) + SUM_BITS'(r_pool_width))
                      >= SUM_BITS'(r_line_width))
                  && ((SUM_BITS'(r_row) + SUM_BITS'(r_pool_height))
                      >= SUM_BITS'(r_plane_height));

        // restart the row maximum at the first sample of each window row
        n_row_max = (r_ox == '0 || i_in.sample > r_row_max) ? i_in.sample : r_row_max;

        // advance the raster position
        n_col = r_col;
        n_row = r_row;
        n_ox  = r_ox;
        n_oy  = r_oy;
        if ((SUM_BITS'(r_col) + SUM_BITS'(1)) >= SUM_BITS'(r_line_width)) begin
            n_col = '0;
            n_ox  = '0;
            if ((SUM_BITS'(r_row) + SUM_BITS'(1)) >= SUM_BITS'(r_plane_height)) begin
                n_row = '0;
                n_oy  = '0;
            end else begin
                n_row = r_row + AW'(1);
                n_oy  = win_y_last ? '0 : r_oy + OW'(1);
            end
        end else begin
            n_col = r_col + AW'(1);
            n_ox  = win_x_last ? '0 : r_ox + OW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_ox      <= '0;
            r_oy      <= '0;
            r_row_max <= '0;
        end else if (i_cfg_we) begin
            // any register write restarts the plane
            r_col     <= '0;
            r_row     <= '0;
            r_ox      <= '0;
            r_oy      <= '0;
            r_row_max <= '0;
        end else if (in_acc) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_ox      <= n_ox;
            r_oy      <= n_oy;
            r_row_max <= n_row_max;
        end
    end

    // ------------------------------------------------------------------
    // Line store of partial column maxima: read on accept, write in stage 1
    // ------------------------------------------------------------------
    logic [AW-1:0]          r_s1_addr;
    logic signed [SAMPLE_BITS-1:0] r_s1_rm;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                   ram_we;
    logic signed [SAMPLE_BITS-1:0] s1_max, s1_col;
    logic                   r_byp;
    logic signed [SAMPLE_BITS-1:0] r_byp_data;

    assign ram_we = s1_adv && r_s1_wr;

    mp2d_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_LINE_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata (s1_max),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        // take the value written in the read cycle when both hit one entry
        s1_col = r_byp ? r_byp_data : $signed(ram_rdata);
        s1_max = (r_s1_merge && s1_col > r_s1_rm) ? s1_col : r_s1_rm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_byp  <= 1'b0;
        end else if (in_acc) begin
            r_s1_v <= 1'b1;
            r_byp  <= ram_we && (r_s1_addr == r_col);
        end else if (s1_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_addr  <= r_col;
            r_s1_rm    <= n_row_max;
            r_s1_wr    <= win_x_last && line_ok && rows_ok;
            r_s1_emit  <= win_x_last && line_ok && rows_ok && win_y_last;
            r_s1_merge <= r_oy != '0;
            r_s1_done  <= plane_last;
            r_byp_data <= s1_max;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] r_o_val;
    logic                          r_o_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s1_adv && r_s1_emit) begin
            r_o_v <= 1'b1;
        end else if (o_out.ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_emit) begin
            r_o_val  <= s1_max;
            r_o_done <= r_s1_done;
        end
    end

    assign o_out.valid        = r_o_v;
    assign o_out.pooled_value = r_o_val;
    assign o_out.plane_done   = r_o_done;

`ifndef SYNTHESIS
    a_col_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_BITS'(r_col) < SUM_BITS'(r_line_width))
        else $error("column position beyond line width");

    a_row_in_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_BITS'(r_row) < SUM_BITS'(r_plane_height))
        else $error("row position beyond plane height");

    a_ox_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PL_BITS'(r_ox) < r_pool_width && PL_BITS'(r_oy) < r_pool_height)
        else $error("window offset beyond pool size");

    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_v) |-> $past(r_s1_v && r_s1_emit))
        else $error("result word without a stage-1 item");

    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_s1_v && r_s1_emit && r_o_v)
        else $error("input stalled with nothing to deliver");
`endif
endmodule
